// ===== design/cfct_pkg.sv =====
`timescale 1ns / 1ps

package cfct_pkg;

    // CAN identifiers
    localparam logic [10:0] MotionId = 11'h260;
    localparam logic [10:0] FwdId    = 11'h000;

    // Turn offset after reset
    localparam logic [31:0] OffsetReset = 32'h0000_003C;

    // Command byte codes
    localparam logic [7:0] CmdStraight = 8'h11;
    localparam logic [7:0] CmdTurn     = 8'h33;
    localparam logic [7:0] CmdLift     = 8'h44;
    localparam logic [7:0] CmdCamera   = 8'h55;
    localparam logic [7:0] CmdFwdA     = 8'h5F;
    localparam logic [7:0] CmdFwdB     = 8'hFE;

    // Mode / direction codes
    localparam logic [7:0] ModeA = 8'hAA;
    localparam logic [7:0] ModeB = 8'hBB;

    // Command queue between front and back
    localparam int QDepth = 4;
    localparam int QPtrW  = $clog2(QDepth);
    localparam int QCntW  = $clog2(QDepth + 1);

    // Frame index within one command (up to five frames)
    localparam int FrameIdxW = 3;

    typedef enum logic [2:0] {
        K_STRAIGHT,
        K_TURN,
        K_LIFT,
        K_CAMERA,
        K_FWD
    } t_kind;

    // One classified command waiting for the frame sequencer
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  cmd;
        logic [7:0]  mode;
        logic [7:0]  param;
        logic [31:0] value;
        logic [7:0]  tail;
        logic [31:0] left;
        logic [31:0] right;
    } t_desc;

    // Number of frames a command emits
    function automatic logic [FrameIdxW-1:0] frame_count(t_kind k);
        logic [FrameIdxW-1:0] n;
        unique case (k)
            K_TURN:  n = FrameIdxW'(5);
            K_FWD:   n = FrameIdxW'(1);
            default: n = FrameIdxW'(2);
        endcase
        return n;
    endfunction

endpackage

// ===== design/cfct_front.sv =====
`timescale 1ns / 1ps

module cfct_front
    import cfct_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic [7:0] i_cmd,
    input  logic [7:0] i_mode_byte,
    input  logic [7:0] i_param_byte,
    input  logic [7:0] i_value_b3,
    input  logic [7:0] i_value_b4,
    input  logic [7:0] i_value_b5,
    input  logic [7:0] i_value_b6,
    input  logic [7:0] i_tail_byte,
    input  logic       i_q_full,
    output logic       o_q_push,
    output t_desc      o_q_data
);

    logic [31:0] r_offset;
    logic [31:0] n_offset;
    logic [31:0] value;
    logic [31:0] v_minus;
    logic [31:0] v_plus;
    logic        is_ab;
    logic        accept;
    logic        emit;
    logic        load_off;
    t_kind       kind;

    // speed math against the current offset
    assign value   = {i_value_b3, i_value_b4, i_value_b5, i_value_b6};
    assign v_minus = value - r_offset;
    assign v_plus  = value + r_offset;
    assign is_ab   = (i_mode_byte == ModeA) || (i_mode_byte == ModeB);
    assign accept  = i_push && !i_q_full;

    // classify the command byte
    always_comb begin
        kind     = K_STRAIGHT;
        emit     = 1'b0;
        load_off = 1'b0;
        unique case (i_cmd) inside
            CmdStraight: begin
                kind = K_STRAIGHT;
                emit = 1'b1;
            end
            CmdTurn: begin
                kind     = K_TURN;
                emit     = is_ab;
                load_off = !is_ab;
            end
            CmdLift: begin
                kind = K_LIFT;
                emit = 1'b1;
            end
            CmdCamera: begin
                kind = K_CAMERA;
                emit = 1'b1;
            end
            CmdFwdA, CmdFwdB: begin
                kind = K_FWD;
                emit = 1'b1;
            end
            default: begin
                kind = K_STRAIGHT;
            end
        endcase
    end

    // descriptor into the queue
    always_comb begin
        o_q_data.kind  = kind;
        o_q_data.cmd   = i_cmd;
        o_q_data.mode  = i_mode_byte;
        o_q_data.param = i_param_byte;
        o_q_data.value = value;
        o_q_data.tail  = i_tail_byte;
        o_q_data.left  = (i_mode_byte == ModeA) ? v_minus : v_plus;
        o_q_data.right = (i_mode_byte == ModeA) ? v_plus : v_minus;
    end

    assign o_q_push = accept && emit;
    assign n_offset = (accept && load_off) ? value : r_offset;

    // turn offset register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= OffsetReset;
        end else begin
            r_offset <= n_offset;
        end
    end

`ifndef SYNTH
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_push |-> !i_q_full)
        else $error("front pushed into a full queue");
    a_load_no_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && load_off) |-> !o_q_push)
        else $error("offset load also produced frames");
    a_offset_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(accept && load_off) |=> $stable(r_offset))
        else $error("turn offset changed without a load");
`endif

endmodule

// ===== design/cfct_queue.sv =====
`timescale 1ns / 1ps

module cfct_queue
    import cfct_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_desc i_data,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_empty,
    output t_desc o_head
);

    t_desc            r_mem [QDepth];
    logic [QPtrW-1:0] r_wptr;
    logic [QPtrW-1:0] r_rptr;
    logic [QCntW-1:0] r_count;
    logic [QPtrW-1:0] n_wptr;
    logic [QPtrW-1:0] n_rptr;
    logic [QCntW-1:0] n_count;

    assign o_full  = (r_count == QCntW'(QDepth));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rptr];

    // pointer and fill count update
    always_comb begin
        n_wptr  = i_push ? r_wptr + 1'b1 : r_wptr;
        n_rptr  = i_pop ? r_rptr + 1'b1 : r_rptr;
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // entry storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

`ifndef SYNTH
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCntW'(QDepth))
        else $error("queue count out of range");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("queue underflow");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wptr - r_rptr) == r_count[QPtrW-1:0])
        else $error("queue pointers disagree with count");
`endif

endmodule

// ===== design/cfct_back.sv =====
`timescale 1ns / 1ps

module cfct_back
    import cfct_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_empty,
    input  t_desc           i_q_head,
    output logic            o_q_pop,
    input  logic            i_pop,
    output logic            o_empty,
    output logic [10:0]     o_can_id,
    output logic [7:0][7:0] o_frame,
    output logic            o_last
);

    logic [FrameIdxW-1:0] r_idx;
    logic [FrameIdxW-1:0] n_idx;
    logic                 r_valid;
    logic                 n_valid;
    logic [10:0]          r_can_id;
    logic [7:0][7:0]      r_frame;
    logic                 r_last;

    logic [FrameIdxW-1:0] cnt;
    logic                 is_last;
    logic                 load;
    logic [10:0]          f_id;
    logic [6:0][7:0]      fb;
    logic [7:0]           f_sum;
    logic [7:0]           f_b7;
    logic [7:0]           side;
    logic [7:0]           sel;
    logic [31:0]          speed;

    assign cnt     = frame_count(i_q_head.kind);
    assign is_last = (r_idx == cnt - 1'b1);
    assign load    = !i_q_empty && (!r_valid || i_pop);
    assign o_q_pop = load && is_last;

    assign side  = (i_q_head.param != 8'h00) ? 8'h11 : 8'h00;
    assign speed = r_idx[0] ? i_q_head.right : i_q_head.left;

    // wheel selector byte of the turn speed frames
    always_comb begin
        case (r_idx[1:0])
            2'd0:    sel = 8'h00;
            2'd1:    sel = 8'h11;
            2'd2:    sel = 8'h22;
            default: sel = 8'h33;
        endcase
    end

    // frame assembly for the head command and current frame index
    always_comb begin
        f_id = MotionId;
        fb   = '0;
        unique case (i_q_head.kind)
            K_STRAIGHT: begin
                fb[0] = 8'h11;
                if (r_idx == '0) begin
                    fb[1] = 8'h11;
                    fb[2] = i_q_head.param;
                    fb[3] = i_q_head.value[31:24];
                    fb[4] = i_q_head.value[23:16];
                    fb[5] = i_q_head.value[15:8];
                    fb[6] = i_q_head.value[7:0];
                end else begin
                    fb[1] = 8'h22;
                    if (i_q_head.mode == ModeA) begin
                        fb[2] = i_q_head.param;
                        fb[3] = 8'h55;
                    end else if (i_q_head.mode == ModeB) begin
                        fb[2] = i_q_head.param;
                        fb[3] = 8'hAA;
                    end else begin
                        fb[2] = 8'hFF;
                        fb[3] = 8'hFF;
                    end
                end
            end
            K_TURN: begin
                fb[0] = 8'h11;
                if (r_idx == FrameIdxW'(4)) begin
                    fb[1] = 8'h22;
                    fb[2] = 8'hEE;
                    fb[3] = 8'h55;
                    fb[4] = 8'h11;
                end else begin
                    fb[1] = 8'h11;
                    fb[2] = sel;
                    fb[3] = speed[31:24];
                    fb[4] = speed[23:16];
                    fb[5] = speed[15:8];
                    fb[6] = speed[7:0];
                end
            end
            K_LIFT, K_CAMERA: begin
                fb[0] = (i_q_head.kind == K_LIFT) ? 8'h44 : 8'h55;
                fb[2] = (i_q_head.kind == K_LIFT) ? 8'h00 : side;
                if (r_idx == '0) begin
                    fb[1] = 8'h33;
                    fb[3] = i_q_head.value[31:24];
                    fb[4] = i_q_head.value[23:16];
                    fb[5] = i_q_head.value[15:8];
                    fb[6] = i_q_head.value[7:0];
                end else begin
                    fb[1] = 8'h22;
                    fb[3] = 8'h55;
                end
            end
            K_FWD: begin
                f_id  = FwdId;
                fb[0] = i_q_head.cmd;
                fb[1] = i_q_head.mode;
                fb[2] = i_q_head.param;
                fb[3] = i_q_head.value[31:24];
                fb[4] = i_q_head.value[23:16];
                fb[5] = i_q_head.value[15:8];
                fb[6] = i_q_head.value[7:0];
            end
            default: begin
                f_id = MotionId;
            end
        endcase
    end

    // checksum byte, mod 256
    always_comb begin
        f_sum = '0;
        for (int k = 0; k < 7; k++) begin
            f_sum = f_sum + fb[k];
        end
        f_b7 = (i_q_head.kind == K_FWD) ? i_q_head.tail : f_sum;
    end

    // frame index and output valid
    always_comb begin
        n_idx   = r_idx;
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
            n_idx   = is_last ? '0 : r_idx + 1'b1;
        end else if (i_pop) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    // output beat register
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_can_id <= f_id;
            r_frame  <= {f_b7, fb};
            r_last   <= is_last;
        end
    end

    assign o_empty  = !r_valid;
    assign o_can_id = r_can_id;
    assign o_frame  = r_frame;
    assign o_last   = r_last;

`ifndef SYNTH
    a_idx_needs_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx != '0) |-> !i_q_empty)
        else $error("frame index advanced with no command queued");
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_q_empty |-> (r_idx < frame_count(i_q_head.kind)))
        else $error("frame index beyond the command's frame count");
    a_pop_marks_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> (r_valid && r_last && (r_idx == '0)))
        else $error("command retired without a last beat");
`endif

endmodule

// ===== design/command_to_can_frame_translator_top.sv =====
`timescale 1ns / 1ps

// Remote motion command to CAN frame translator.
// Input channel: one 8-byte command per beat, taken when push is high and
// full is low. Output channel: CAN frames (id, 8 payload bytes, last flag);
// the oldest frame sits on the ports while empty is low and leaves when
// pop is high. The final frame of each command carries last = 1.
// Straight, lift and camera commands give 2 frames, a turn command in mode
// AA/BB gives 5, forward commands give 1; a turn in any other mode only
// loads the turn offset, and unknown commands give nothing.
// A beat is queued, and its first frame then loads the output register.
// Throughput: the frame sequencer emits one frame per cycle while the
// receiver pops each frame, so a command holds it until all of its frames
// (1 to 5) are out; a 4-entry command queue lets the input keep taking
// beats meanwhile, and full rises only when that queue is full.
// If the receiver stalls, the current frame holds on the ports, the
// sequencer stops, and the queue fills before push is refused.
// Reset (synchronous, active low) empties the queue and the output
// register and sets the turn offset to 0x3C.
module command_to_can_frame_translator_top
    import cfct_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_cmd,
    input  logic [7:0]  i_mode_byte,
    input  logic [7:0]  i_param_byte,
    input  logic [7:0]  i_value_b3,
    input  logic [7:0]  i_value_b4,
    input  logic [7:0]  i_value_b5,
    input  logic [7:0]  i_value_b6,
    input  logic [7:0]  i_tail_byte,
    output logic        empty,
    input  logic        pop,
    output logic [10:0] o_can_id,
    output logic [7:0]  o_frame_b0,
    output logic [7:0]  o_frame_b1,
    output logic [7:0]  o_frame_b2,
    output logic [7:0]  o_frame_b3,
    output logic [7:0]  o_frame_b4,
    output logic [7:0]  o_frame_b5,
    output logic [7:0]  o_frame_b6,
    output logic [7:0]  o_frame_b7,
    output logic        o_last
);

    logic            q_push;
    logic            q_pop;
    logic            q_full;
    logic            q_empty;
    t_desc           q_in;
    t_desc           q_head;
    logic [7:0][7:0] frame;

    cfct_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_cmd        (i_cmd),
        .i_mode_byte  (i_mode_byte),
        .i_param_byte (i_param_byte),
        .i_value_b3   (i_value_b3),
        .i_value_b4   (i_value_b4),
        .i_value_b5   (i_value_b5),
        .i_value_b6   (i_value_b6),
        .i_tail_byte  (i_tail_byte),
        .i_q_full     (q_full),
        .o_q_push     (q_push),
        .o_q_data     (q_in)
    );

    cfct_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    cfct_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_head  (q_head),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_can_id  (o_can_id),
        .o_frame   (frame),
        .o_last    (o_last)
    );

    assign full       = q_full;
    assign o_frame_b0 = frame[0];
    assign o_frame_b1 = frame[1];
    assign o_frame_b2 = frame[2];
    assign o_frame_b3 = frame[3];
    assign o_frame_b4 = frame[4];
    assign o_frame_b5 = frame[5];
    assign o_frame_b6 = frame[6];
    assign o_frame_b7 = frame[7];

endmodule

// ===== tb/command_to_can_frame_translator_top_tb.sv =====
`timescale 1ns / 1ps

module command_to_can_frame_translator_top_tb;
    import cfct_pkg::*;

    // Payload codes used in motion frames
    localparam logic [7:0] SubSpeed  = 8'h11;
    localparam logic [7:0] SubDir    = 8'h22;
    localparam logic [7:0] SubLoad   = 8'h33;
    localparam logic [7:0] SelLeftA  = 8'h00;
    localparam logic [7:0] SelRightA = 8'h11;
    localparam logic [7:0] SelLeftB  = 8'h22;
    localparam logic [7:0] SelRightB = 8'h33;
    localparam logic [7:0] TurnEnd   = 8'hEE;
    localparam logic [7:0] DirFwd    = 8'h55;
    localparam logic [7:0] DirRev    = 8'hAA;
    localparam logic [7:0] DirNone   = 8'hFF;
    localparam logic [7:0] SideOn    = 8'h11;
    localparam logic [7:0] SideOff   = 8'h00;

    // random commands on top of the directed ones
    localparam int RandomCommands = 247;

    typedef struct packed {
        logic [7:0]  cmd;
        logic [7:0]  mode;
        logic [7:0]  param;
        logic [31:0] value;
        logic [7:0]  tail;
    } t_motion_cmd;

    typedef struct packed {
        logic [10:0]     can_id;
        logic [7:0][7:0] data;
        logic            last;
    } t_can_frame;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  i_cmd = '0;
    logic [7:0]  i_mode_byte = '0;
    logic [7:0]  i_param_byte = '0;
    logic [7:0]  i_value_b3 = '0;
    logic [7:0]  i_value_b4 = '0;
    logic [7:0]  i_value_b5 = '0;
    logic [7:0]  i_value_b6 = '0;
    logic [7:0]  i_tail_byte = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [10:0] o_can_id;
    logic [7:0]  o_frame_b0;
    logic [7:0]  o_frame_b1;
    logic [7:0]  o_frame_b2;
    logic [7:0]  o_frame_b3;
    logic [7:0]  o_frame_b4;
    logic [7:0]  o_frame_b5;
    logic [7:0]  o_frame_b6;
    logic [7:0]  o_frame_b7;
    logic        o_last;

    // Frames the translator owes us, oldest first
    t_can_frame  pending_frames[$];
    logic [31:0] offset_model;
    int          err_count = 0;
    int          burst_left = 0;
    bit          draining = 1'b0;

    command_to_can_frame_translator_top i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_cmd        (i_cmd),
        .i_mode_byte  (i_mode_byte),
        .i_param_byte (i_param_byte),
        .i_value_b3   (i_value_b3),
        .i_value_b4   (i_value_b4),
        .i_value_b5   (i_value_b5),
        .i_value_b6   (i_value_b6),
        .i_tail_byte  (i_tail_byte),
        .empty        (empty),
        .pop          (pop),
        .o_can_id     (o_can_id),
        .o_frame_b0   (o_frame_b0),
        .o_frame_b1   (o_frame_b1),
        .o_frame_b2   (o_frame_b2),
        .o_frame_b3   (o_frame_b3),
        .o_frame_b4   (o_frame_b4),
        .o_frame_b5   (o_frame_b5),
        .o_frame_b6   (o_frame_b6),
        .o_frame_b7   (o_frame_b7),
        .o_last       (o_last)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Generic frame into the expected store
    task automatic queue_frame(input logic [10:0] id, input logic [7:0] b0, input logic [7:0] b1,
                               input logic [7:0] b2, input logic [7:0] b3, input logic [7:0] b4,
                               input logic [7:0] b5, input logic [7:0] b6, input logic [7:0] b7);
        t_can_frame f;
        f.can_id = id;
        f.data   = {b7, b6, b5, b4, b3, b2, b1, b0};
        f.last   = 1'b0;
        pending_frames.push_back(f);
    endtask

    // Motion frame: byte 7 is the 8-bit sum of bytes 0..6
    task automatic queue_motion(input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2,
                                input logic [7:0] b3, input logic [7:0] b4, input logic [7:0] b5,
                                input logic [7:0] b6);
        logic [7:0] sum;
        sum = b0 + b1 + b2 + b3 + b4 + b5 + b6;
        queue_frame(MotionId, b0, b1, b2, b3, b4, b5, b6, sum);
    endtask

    task automatic queue_speed(input logic [7:0] sel, input logic [31:0] speed);
        queue_motion(SubSpeed, SubSpeed, sel, speed[31:24], speed[23:16], speed[15:8], speed[7:0]);
    endtask

    // Expected frames for one accepted command; updates the offset copy
    task automatic predict_frames(input t_motion_cmd c);
        int          n_before;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [7:0]  side;
        t_can_frame  f;
        n_before = pending_frames.size();
        lo = c.value - offset_model;
        hi = c.value + offset_model;
        side = (c.param == 8'h00) ? SideOff : SideOn;
        case (c.cmd) inside
            CmdStraight: begin
                queue_motion(SubSpeed, SubSpeed, c.param, c.value[31:24], c.value[23:16],
                             c.value[15:8], c.value[7:0]);
                if (c.mode == ModeA)
                    queue_motion(SubSpeed, SubDir, c.param, DirFwd, 8'h00, 8'h00, 8'h00);
                else if (c.mode == ModeB)
                    queue_motion(SubSpeed, SubDir, c.param, DirRev, 8'h00, 8'h00, 8'h00);
                else
                    queue_motion(SubSpeed, SubDir, DirNone, DirNone, 8'h00, 8'h00, 8'h00);
            end
            CmdTurn: begin
                if (c.mode == ModeA || c.mode == ModeB) begin
                    // mode A: left slows, right speeds up; mode B the other way round
                    queue_speed(SelLeftA,  (c.mode == ModeA) ? lo : hi);
                    queue_speed(SelRightA, (c.mode == ModeA) ? hi : lo);
                    queue_speed(SelLeftB,  (c.mode == ModeA) ? lo : hi);
                    queue_speed(SelRightB, (c.mode == ModeA) ? hi : lo);
                    queue_motion(SubSpeed, SubDir, TurnEnd, DirFwd, SubSpeed, 8'h00, 8'h00);
                end else begin
                    offset_model = c.value;
                end
            end
            CmdLift: begin
                queue_motion(CmdLift, SubLoad, 8'h00, c.value[31:24], c.value[23:16],
                             c.value[15:8], c.value[7:0]);
                queue_motion(CmdLift, SubDir, 8'h00, DirFwd, 8'h00, 8'h00, 8'h00);
            end
            CmdCamera: begin
                queue_motion(CmdCamera, SubLoad, side, c.value[31:24], c.value[23:16],
                             c.value[15:8], c.value[7:0]);
                queue_motion(CmdCamera, SubDir, side, DirFwd, 8'h00, 8'h00, 8'h00);
            end
            CmdFwdA, CmdFwdB: begin
                queue_frame(FwdId, c.cmd, c.mode, c.param, c.value[31:24], c.value[23:16],
                            c.value[15:8], c.value[7:0], c.tail);
            end
            default: begin
            end
        endcase
        // tag the final frame of this command
        if (pending_frames.size() > n_before) begin
            f = pending_frames.pop_back();
            f.last = 1'b1;
            pending_frames.push_back(f);
        end
    endtask

    // One input beat; the sender idles between bursts of random length
    task automatic send_command(input t_motion_cmd c);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 20) : $urandom_range(1, 3);
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(1, 8);
        end
        burst_left--;
        push         <= 1'b1;
        i_cmd        <= c.cmd;
        i_mode_byte  <= c.mode;
        i_param_byte <= c.param;
        i_value_b3   <= c.value[31:24];
        i_value_b4   <= c.value[23:16];
        i_value_b5   <= c.value[15:8];
        i_value_b6   <= c.value[7:0];
        i_tail_byte  <= c.tail;
        do @(posedge i_clk); while (full);
        predict_frames(c);
    endtask

    function automatic t_motion_cmd mk_cmd(input logic [7:0] cmd, input logic [7:0] mode,
                                           input logic [7:0] param, input logic [31:0] value,
                                           input logic [7:0] tail);
        t_motion_cmd c;
        c.cmd   = cmd;
        c.mode  = mode;
        c.param = param;
        c.value = value;
        c.tail  = tail;
        return c;
    endfunction

    // Mostly well-formed commands with random content, some noise bytes
    function automatic t_motion_cmd random_command();
        t_motion_cmd c;
        int          pick;
        c.mode  = 8'($urandom);
        c.param = 8'($urandom);
        c.value = $urandom;
        c.tail  = 8'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 20)      c.cmd = CmdStraight;
        else if (pick < 50) c.cmd = CmdTurn;
        else if (pick < 62) c.cmd = CmdLift;
        else if (pick < 74) c.cmd = CmdCamera;
        else if (pick < 80) c.cmd = CmdFwdA;
        else if (pick < 86) c.cmd = CmdFwdB;
        else                c.cmd = 8'($urandom);
        if (c.cmd == CmdStraight || c.cmd == CmdTurn) begin
            pick = $urandom_range(0, 9);
            if (pick < 4)      c.mode = ModeA;
            else if (pick < 8) c.mode = ModeB;
        end
        if (c.cmd == CmdCamera && $urandom_range(0, 3) == 0)
            c.param = 8'h00;
        // edge values, and small offsets so turn speeds land near zero
        pick = $urandom_range(0, 7);
        if (pick == 0)      c.value = 32'h0000_0000;
        else if (pick == 1) c.value = 32'hFFFF_FFFF;
        else if (pick == 2) c.value = $urandom_range(0, 255);
        return c;
    endfunction

    // Receiver: checks each popped frame; the pop pattern comes from a randomly picked mode
    int rx_cycle = 0;
    int rx_mode = 0;
    always @(posedge i_clk) begin : rx_check
        t_can_frame      exp_f;
        logic [7:0][7:0] got;
        got = {o_frame_b7, o_frame_b6, o_frame_b5, o_frame_b4,
               o_frame_b3, o_frame_b2, o_frame_b1, o_frame_b0};
        if (i_rst_n && pop && !empty) begin
            if (pending_frames.size() == 0) begin
                $display("%0t: frame with nothing expected: id %h data %h last %b",
                         $time, o_can_id, got, o_last);
                err_count++;
            end else begin
                exp_f = pending_frames.pop_front();
                if (exp_f.can_id !== o_can_id) begin
                    $display("%0t: can_id expected %h actual %h", $time, exp_f.can_id, o_can_id);
                    err_count++;
                end
                for (int k = 0; k < 8; k++) begin
                    if (exp_f.data[k] !== got[k]) begin
                        $display("%0t: frame_b%0d expected %h actual %h",
                                 $time, k, exp_f.data[k], got[k]);
                        err_count++;
                    end
                end
                if (exp_f.last !== o_last) begin
                    $display("%0t: last expected %b actual %b", $time, exp_f.last, o_last);
                    err_count++;
                end
            end
        end
        // next pop
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (draining) begin
            pop <= 1'b1;
        end else begin
            rx_cycle++;
            if (rx_cycle % 64 == 0)
                rx_mode = $urandom_range(0, 3);
            case (rx_mode)
                0:       pop <= 1'b1;
                1:       pop <= $urandom_range(0, 1);
                2:       pop <= ($urandom_range(0, 7) == 0);
                default: pop <= ((rx_cycle % 16) >= 10);
            endcase
        end
    end

    task automatic test_straight();
        send_command(mk_cmd(CmdStraight, ModeA, 8'h00, 32'h0000_0000, 8'h00));
        send_command(mk_cmd(CmdStraight, ModeB, 8'hFF, 32'hFFFF_FFFF, 8'hFF));
        send_command(mk_cmd(CmdStraight, 8'h00, 8'h7F, 32'h1234_5678, 8'h5A));
        send_command(mk_cmd(CmdStraight, 8'hFF, 8'h80, 32'h8000_0001, 8'hA5));
    endtask

    task automatic test_turn();
        // wrap below zero and above 2^32 with the reset offset
        send_command(mk_cmd(CmdTurn, ModeA, 8'h00, 32'h0000_0000, 8'h00));
        send_command(mk_cmd(CmdTurn, ModeB, 8'hFF, 32'hFFFF_FFFF, 8'hFF));
        // other modes only load the offset
        send_command(mk_cmd(CmdTurn, 8'h00, 8'h00, 32'hFFFF_FFFF, 8'h00));
        send_command(mk_cmd(CmdTurn, ModeA, 8'h12, 32'h0000_0000, 8'h34));
        send_command(mk_cmd(CmdTurn, 8'hFF, 8'h00, 32'h0000_0000, 8'h00));
        send_command(mk_cmd(CmdTurn, ModeB, 8'h00, 32'h1234_5678, 8'h00));
        send_command(mk_cmd(CmdTurn, 8'hAB, 8'h00, 32'h0000_003C, 8'h00));
        send_command(mk_cmd(CmdTurn, ModeA, 8'h00, 32'h8000_0000, 8'h00));
    endtask

    task automatic test_lift_camera();
        send_command(mk_cmd(CmdLift, 8'h00, 8'h00, 32'h0000_0000, 8'h00));
        send_command(mk_cmd(CmdLift, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 8'hFF));
        send_command(mk_cmd(CmdCamera, ModeA, 8'h00, 32'hFFFF_FFFF, 8'h00));
        send_command(mk_cmd(CmdCamera, ModeB, 8'h01, 32'h0000_0000, 8'hFF));
        send_command(mk_cmd(CmdCamera, 8'h00, 8'hFF, 32'hDEAD_BEEF, 8'h11));
    endtask

    task automatic test_forward_unknown();
        send_command(mk_cmd(CmdFwdA, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 8'hFF));
        send_command(mk_cmd(CmdFwdB, 8'h00, 8'h00, 32'h0000_0000, 8'h00));
        send_command(mk_cmd(CmdFwdB, ModeA, 8'h5C, 32'h0102_0304, 8'hC3));
        // unknown command bytes give no frame
        send_command(mk_cmd(8'h00, ModeA, 8'h00, 32'h0000_0000, 8'h00));
        send_command(mk_cmd(8'hFF, ModeB, 8'hFF, 32'hFFFF_FFFF, 8'hFF));
        send_command(mk_cmd(8'h12, 8'h00, 8'h01, 32'h1111_1111, 8'h01));
    endtask

    task automatic test_random_mix();
        t_motion_cmd c;
        for (int k = 0; k < RandomCommands; k++) begin
            c = random_command();
            send_command(c);
        end
    endtask

    initial begin
        offset_model = OffsetReset;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_straight();
        test_turn();
        test_lift_camera();
        test_forward_unknown();
        test_random_mix();
        push <= 1'b0;
        draining = 1'b1;
        while (pending_frames.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (err_count == 0 && pending_frames.size() == 0) begin
            $display("** command_to_can_frame_translator_top: PASSED **");
        end else begin
            $display("** command_to_can_frame_translator_top: FAILED **");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #4_000_000;
        $display("** command_to_can_frame_translator_top: FAILED **");
        $finish;
    end

endmodule
